// ===== rtl/ppsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ppsc_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int VEC_W        = 37;
    localparam int ROT_W        = 33;
    localparam int RZ_W         = 34;
    localparam int NUM_W        = 48;
    localparam int DEN_W        = 36;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 33'sd652032874;

    localparam logic [31:0] ANG_TAB [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] orient_x;
        logic signed [15:0] orient_y;
        logic signed [15:0] orient_z;
        logic signed [15:0] orient_w;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [15:0] forward_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] linear_rate;
        logic signed [31:0] turn_rate;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/ppsc_vec.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ppsc_vec (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic signed [ppsc_pkg::VEC_W-1:0]   i_x,
    input  wire logic signed [ppsc_pkg::VEC_W-1:0]   i_y,
    input  wire logic        [15:0]                  i_side,
    output logic                                     o_valid,
    output logic             [31:0]                  o_angle,
    output logic             [15:0]                  o_side
);
    import ppsc_pkg::*;

    logic signed [VEC_W-1:0] r_x   [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0] r_y   [0:CORDIC_STEPS];
    logic        [31:0]      r_z   [0:CORDIC_STEPS];
    logic                    r_frz [0:CORDIC_STEPS];
    logic        [15:0]      r_side[0:CORDIC_STEPS];
    logic                    r_valid[0:CORDIC_STEPS];

    logic signed [VEC_W-1:0] n_x   [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0] n_y   [0:CORDIC_STEPS];
    logic        [31:0]      n_z   [0:CORDIC_STEPS];
    logic                    n_frz0;

    always_comb begin
        n_x[0]  = i_x;
        n_y[0]  = i_y;
        n_z[0]  = '0;
        n_frz0  = 1'b0;
        if (i_y == '0) begin
            n_frz0 = 1'b1;
            n_z[0] = i_x[VEC_W-1] ? HALF_TURN : 32'h0;
        end else if (i_x == '0) begin
            n_frz0 = 1'b1;
            n_z[0] = i_y[VEC_W-1] ? (32'h0 - QUARTER_TURN) : QUARTER_TURN;
        end else if (i_x[VEC_W-1]) begin
            n_x[0] = -i_x;
            n_y[0] = -i_y;
            n_z[0] = HALF_TURN;
        end
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            n_x[k] = r_x[k-1];
            n_y[k] = r_y[k-1];
            n_z[k] = r_z[k-1];
            if (!r_frz[k-1]) begin
                if (r_y[k-1] > 0) begin
                    n_x[k] = r_x[k-1] + (r_y[k-1] >>> (k-1));
                    n_y[k] = r_y[k-1] - (r_x[k-1] >>> (k-1));
                    n_z[k] = r_z[k-1] + ANG_TAB[k-1];
                end else begin
                    n_x[k] = r_x[k-1] - (r_y[k-1] >>> (k-1));
                    n_y[k] = r_y[k-1] + (r_x[k-1] >>> (k-1));
                    n_z[k] = r_z[k-1] - ANG_TAB[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_frz[0]  <= n_frz0;
            r_side[0] <= i_side;
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_frz[k]  <= r_frz[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    assign o_valid = r_valid[CORDIC_STEPS];
    assign o_angle = r_z[CORDIC_STEPS];
    assign o_side  = r_side[CORDIC_STEPS];

endmodule
`default_nettype wire

// ===== rtl/ppsc_sin.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ppsc_sin (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic signed [ppsc_pkg::RZ_W-1:0]    i_z,
    input  wire logic        [15:0]                  i_side,
    output logic                                     o_valid,
    output logic signed      [ppsc_pkg::ROT_W-1:0]   o_sin,
    output logic             [15:0]                  o_side
);
    import ppsc_pkg::*;

    logic signed [ROT_W-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [ROT_W-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [RZ_W-1:0]  r_z    [0:CORDIC_STEPS];
    logic        [15:0]      r_side [0:CORDIC_STEPS];
    logic                    r_valid[0:CORDIC_STEPS];

    logic signed [ROT_W-1:0] n_x [1:CORDIC_STEPS];
    logic signed [ROT_W-1:0] n_y [1:CORDIC_STEPS];
    logic signed [RZ_W-1:0]  n_z [1:CORDIC_STEPS];

    always_comb begin
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            if (!r_z[k-1][RZ_W-1]) begin
                n_x[k] = r_x[k-1] - (r_y[k-1] >>> (k-1));
                n_y[k] = r_y[k-1] + (r_x[k-1] >>> (k-1));
                n_z[k] = r_z[k-1] - $signed({2'b00, ANG_TAB[k-1]});
            end else begin
                n_x[k] = r_x[k-1] + (r_y[k-1] >>> (k-1));
                n_y[k] = r_y[k-1] - (r_x[k-1] >>> (k-1));
                n_z[k] = r_z[k-1] + $signed({2'b00, ANG_TAB[k-1]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= INV_GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= i_z;
            r_side[0] <= i_side;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_x[k]    <= n_x[k];
                r_y[k]    <= n_y[k];
                r_z[k]    <= n_z[k];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    assign o_valid = r_valid[CORDIC_STEPS];
    assign o_sin   = r_y[CORDIC_STEPS];
    assign o_side  = r_side[CORDIC_STEPS];

endmodule
`default_nettype wire

// ===== rtl/ppsc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ppsc_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [ppsc_pkg::NUM_W-1:0]     i_num,
    input  wire logic [ppsc_pkg::DEN_W-1:0]     i_den,
    input  wire logic                           i_neg,
    input  wire logic [15:0]                    i_side,
    output logic                                o_valid,
    output logic      [ppsc_pkg::NUM_W-1:0]     o_quot,
    output logic                                o_neg,
    output logic      [15:0]                    o_side
);
    import ppsc_pkg::*;

    logic [NUM_W-1:0] r_num  [0:NUM_W];
    logic [DEN_W-1:0] r_rem  [0:NUM_W];
    logic             r_neg  [0:NUM_W];
    logic [15:0]      r_side [0:NUM_W];
    logic             r_valid[0:NUM_W];

    logic [NUM_W-1:0] n_num  [1:NUM_W];
    logic [DEN_W-1:0] n_rem  [1:NUM_W];
    logic [DEN_W:0]   w_trial[1:NUM_W];
    logic             w_ge   [1:NUM_W];

    always_comb begin
        for (int k = 1; k <= NUM_W; k++) begin
            w_trial[k] = {r_rem[k-1], r_num[k-1][NUM_W-1]};
            w_ge[k]    = (w_trial[k] >= {1'b0, i_den});
            n_rem[k]   = w_ge[k] ? DEN_W'(w_trial[k] - {1'b0, i_den})
                                 : w_trial[k][DEN_W-1:0];
            n_num[k]   = {r_num[k-1][NUM_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= i_num;
            r_rem[0]  <= '0;
            r_neg[0]  <= i_neg;
            r_side[0] <= i_side;
            for (int k = 1; k <= NUM_W; k++) begin
                r_num[k]  <= n_num[k];
                r_rem[k]  <= n_rem[k];
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k <= NUM_W; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    assign o_valid = r_valid[NUM_W];
    assign o_quot  = r_num[NUM_W];
    assign o_neg   = r_neg[NUM_W];
    assign o_side  = r_side[NUM_W];

endmodule
`default_nettype wire

// ===== rtl/pure_pursuit_steering_command.sv =====
// Pure pursuit steering command.
// Input channel: i_valid, i_data and o_stall carry one pose, target and speed per
// transaction; a transaction completes on a clock edge with i_valid high and
// o_stall low. Output channel: o_valid, o_data and i_stall carry the linear rate
// (speed passed through) and the turn rate 2*v*sin(alpha)/lookahead in Q16.16.
// The user must write the lookahead register through i_cfg_we and i_cfg_data
// only while idle; the block itself does not enforce this. The pipeline is
// an input register, a multiplier stage, 29 stages of vectoring CORDIC (yaw
// and bearing side by side), an angle wrap stage, 29 stages of rotation
// CORDIC, a product stage, a rounding stage, 49 stages of restoring division
// and the output register. Throughput is one transaction per cycle while the
// receiver does not stall, set by the fully pipelined CORDIC and divider stages.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises; nothing is lost or repeated. Synchronous reset clears
// every valid bit and sets the lookahead to 1.0 m.
`timescale 1ns / 1ps
`default_nettype none
module pure_pursuit_steering_command (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire ppsc_pkg::t_in_item    i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output ppsc_pkg::t_out_item        o_data,
    input  wire logic                  i_stall,
    input  wire logic                  i_cfg_we,
    input  wire logic [30:0]           i_cfg_data
);
    import ppsc_pkg::*;

    logic        w_en;
    logic [30:0] r_look;

    t_in_item    r_in;
    logic        r_in_valid;

    logic signed [31:0] r_p_wz, r_p_xy, r_p_yy, r_p_zz;
    logic signed [32:0] r_dx, r_dy;
    logic        [15:0] r_v1;
    logic               r_valid1;

    logic signed [VEC_W-1:0] w_yn, w_yd, w_bx, w_by;

    logic        w_yaw_valid, w_brg_valid;
    logic [31:0] w_yaw, w_brg;
    logic [15:0] w_v2;

    logic signed [32:0]      w_alpha;
    logic signed [RZ_W-1:0]  n_z;
    logic signed [RZ_W-1:0]  r_z;
    logic [15:0]             r_v3;
    logic                    r_valid3;

    logic                    w_sin_valid;
    logic signed [ROT_W-1:0] w_sin;
    logic [15:0]             w_v4;

    logic signed [48:0] r_prod;
    logic [15:0]        r_v5;
    logic               r_valid5;

    logic [30:0]        w_look_eff;
    logic [DEN_W-1:0]   w_den;
    logic [48:0]        w_mag;
    logic [NUM_W-1:0]   r_num;
    logic               r_neg;
    logic [15:0]        r_v6;
    logic               r_valid6;

    logic               w_div_valid;
    logic [NUM_W-1:0]   w_quot;
    logic               w_qneg;
    logic [15:0]        w_v7;
    logic signed [31:0] n_turn;

    t_out_item          r_out;
    logic               r_out_valid;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look <= 31'd65536;
        end else if (i_cfg_we) begin
            r_look <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_valid1    <= 1'b0;
            r_valid3    <= 1'b0;
            r_valid5    <= 1'b0;
            r_valid6    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid  <= i_valid;
            r_valid1    <= r_in_valid;
            r_valid3    <= w_yaw_valid && w_brg_valid;
            r_valid5    <= w_sin_valid;
            r_valid6    <= r_valid5;
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in   <= i_data;
            r_p_wz <= r_in.orient_w * r_in.orient_z;
            r_p_xy <= r_in.orient_x * r_in.orient_y;
            r_p_yy <= r_in.orient_y * r_in.orient_y;
            r_p_zz <= r_in.orient_z * r_in.orient_z;
            r_dx   <= 33'(r_in.goal_x) - 33'(r_in.robot_x);
            r_dy   <= 33'(r_in.goal_y) - 33'(r_in.robot_y);
            r_v1   <= r_in.forward_speed;
        end
    end

    assign w_yn = (VEC_W'(r_p_wz) + VEC_W'(r_p_xy)) <<< 1;
    assign w_yd = (VEC_W'(1) <<< 28) - ((VEC_W'(r_p_yy) + VEC_W'(r_p_zz)) <<< 1);
    assign w_bx = VEC_W'(r_dx);
    assign w_by = VEC_W'(r_dy);

    ppsc_vec u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_valid1),
        .i_x     (w_yd),
        .i_y     (w_yn),
        .i_side  (r_v1),
        .o_valid (w_yaw_valid),
        .o_angle (w_yaw),
        .o_side  (w_v2)
    );

    ppsc_vec u_brg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_valid1),
        .i_x     (w_bx),
        .i_y     (w_by),
        .i_side  (16'h0000),
        .o_valid (w_brg_valid),
        .o_angle (w_brg),
        .o_side  ()
    );

    always_comb begin
        w_alpha = 33'($signed(w_brg - w_yaw));
        if (w_alpha > $signed({1'b0, QUARTER_TURN})) begin
            n_z = RZ_W'($signed({1'b0, HALF_TURN}) - w_alpha);
        end else if (w_alpha < -$signed({1'b0, QUARTER_TURN})) begin
            n_z = RZ_W'(-$signed({1'b0, HALF_TURN}) - w_alpha);
        end else begin
            n_z = RZ_W'(w_alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z  <= n_z;
            r_v3 <= w_v2;
        end
    end

    ppsc_sin u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_valid3),
        .i_z     (r_z),
        .i_side  (r_v3),
        .o_valid (w_sin_valid),
        .o_sin   (w_sin),
        .o_side  (w_v4)
    );

    assign w_look_eff = (r_look == '0) ? 31'd1 : r_look;
    assign w_den      = {w_look_eff, 5'b00000};
    assign w_mag      = r_prod[48] ? 49'(-r_prod) : 49'(r_prod);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= $signed(w_v4) * w_sin;
            r_v5   <= w_v4;
            r_num  <= NUM_W'(w_mag[NUM_W-1:0] + NUM_W'({w_look_eff, 4'b0000}));
            r_neg  <= r_prod[48];
            r_v6   <= r_v5;
        end
    end

    ppsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_valid6),
        .i_num   (r_num),
        .i_den   (w_den),
        .i_neg   (r_neg),
        .i_side  (r_v6),
        .o_valid (w_div_valid),
        .o_quot  (w_quot),
        .o_neg   (w_qneg),
        .o_side  (w_v7)
    );

    always_comb begin
        if (w_qneg) begin
            n_turn = (w_quot > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                       : -$signed(w_quot[31:0]);
        end else begin
            n_turn = (w_quot > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                     : $signed(w_quot[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.linear_rate <= w_v7;
            r_out.turn_rate   <= n_turn;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire
